>>> hw/rtl/assert_macros.svh
// Assertion macros for the pose offset unit.
// Uses the clk_i and rst_ni names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define QPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define QPO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/qpo_pkg.sv
// Shared widths, register indexes, product indexes and beat types of the pose offset unit.
// No dependencies.
package qpo_pkg;

  localparam int QuatW   = 16;
  localparam int PosW    = 32;
  localparam int OffW    = 32;
  localparam int NumOff  = 3;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = 2 * QuatW;
  localparam int NumProd = 9;
  localparam int NumEnt  = 9;

  localparam int QuatFracBitsDefault = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_reg_e;

  localparam int PROD_XX = 0;
  localparam int PROD_YY = 1;
  localparam int PROD_ZZ = 2;
  localparam int PROD_XY = 3;
  localparam int PROD_XZ = 4;
  localparam int PROD_YZ = 5;
  localparam int PROD_WX = 6;
  localparam int PROD_WY = 7;
  localparam int PROD_WZ = 8;

  typedef struct packed {
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [PosW-1:0]  pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0]  out_x;
    logic signed [PosW-1:0]  out_y;
    logic signed [PosW-1:0]  out_z;
    logic signed [QuatW-1:0] out_qw;
    logic signed [QuatW-1:0] out_qx;
    logic signed [QuatW-1:0] out_qy;
    logic signed [QuatW-1:0] out_qz;
  } out_item_t;

endpackage

>>> hw/rtl/qpo_prod.sv
// Stage one: the nine quaternion cross products, registered.
// Depends on qpo_pkg.
module qpo_prod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  qpo_pkg::in_item_t                   item_i,
  input  logic                                ready_i,
  output logic                                valid_o,
  output qpo_pkg::in_item_t                   item_o,
  output logic signed [qpo_pkg::ProdW-1:0]    prod_o [qpo_pkg::NumProd]
);

  logic                             valid_q;
  qpo_pkg::in_item_t                item_q;
  logic signed [qpo_pkg::ProdW-1:0] prod_d [qpo_pkg::NumProd];
  logic signed [qpo_pkg::ProdW-1:0] prod_q [qpo_pkg::NumProd];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod_d[qpo_pkg::PROD_XX] = item_i.quat_x * item_i.quat_x;
    prod_d[qpo_pkg::PROD_YY] = item_i.quat_y * item_i.quat_y;
    prod_d[qpo_pkg::PROD_ZZ] = item_i.quat_z * item_i.quat_z;
    prod_d[qpo_pkg::PROD_XY] = item_i.quat_x * item_i.quat_y;
    prod_d[qpo_pkg::PROD_XZ] = item_i.quat_x * item_i.quat_z;
    prod_d[qpo_pkg::PROD_YZ] = item_i.quat_y * item_i.quat_z;
    prod_d[qpo_pkg::PROD_WX] = item_i.quat_w * item_i.quat_x;
    prod_d[qpo_pkg::PROD_WY] = item_i.quat_w * item_i.quat_y;
    prod_d[qpo_pkg::PROD_WZ] = item_i.quat_w * item_i.quat_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign prod_o  = prod_q;

endmodule

>>> hw/rtl/qpo_matrix.sv
// Stage two: rotation matrix entries from the products, rounded to the quaternion format.
// Depends on qpo_pkg.
module qpo_matrix #(
  parameter int QuatFracBits = qpo_pkg::QuatFracBitsDefault,
  localparam int EntW = (((2 * QuatFracBits + 2) > (qpo_pkg::ProdW + 2)) ?
                         (2 * QuatFracBits + 2) : (qpo_pkg::ProdW + 2)) + 1,
  localparam int MatW = EntW - QuatFracBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  qpo_pkg::in_item_t                 item_i,
  input  logic signed [qpo_pkg::ProdW-1:0]  prod_i [qpo_pkg::NumProd],
  input  logic                              ready_i,
  output logic                              valid_o,
  output qpo_pkg::in_item_t                 item_o,
  output logic signed [MatW-1:0]            mat_o [qpo_pkg::NumEnt]
);

  localparam logic signed [EntW-1:0] One  = EntW'(1) << (2 * QuatFracBits);
  localparam logic signed [EntW-1:0] Half = EntW'(1) << (QuatFracBits - 1);

  logic                      valid_q;
  qpo_pkg::in_item_t         item_q;
  logic signed [EntW-1:0]    pe    [qpo_pkg::NumProd];
  logic signed [EntW-1:0]    ent   [qpo_pkg::NumEnt];
  logic signed [EntW-1:0]    rnd   [qpo_pkg::NumEnt];
  logic signed [MatW-1:0]    mat_d [qpo_pkg::NumEnt];
  logic signed [MatW-1:0]    mat_q [qpo_pkg::NumEnt];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int i = 0; i < qpo_pkg::NumProd; i++) begin
      pe[i] = EntW'(prod_i[i]);
    end
    ent[0] = One - ((pe[qpo_pkg::PROD_YY] + pe[qpo_pkg::PROD_ZZ]) <<< 1);
    ent[1] = (pe[qpo_pkg::PROD_XY] - pe[qpo_pkg::PROD_WZ]) <<< 1;
    ent[2] = (pe[qpo_pkg::PROD_XZ] + pe[qpo_pkg::PROD_WY]) <<< 1;
    ent[3] = (pe[qpo_pkg::PROD_XY] + pe[qpo_pkg::PROD_WZ]) <<< 1;
    ent[4] = One - ((pe[qpo_pkg::PROD_XX] + pe[qpo_pkg::PROD_ZZ]) <<< 1);
    ent[5] = (pe[qpo_pkg::PROD_YZ] - pe[qpo_pkg::PROD_WX]) <<< 1;
    ent[6] = (pe[qpo_pkg::PROD_XZ] - pe[qpo_pkg::PROD_WY]) <<< 1;
    ent[7] = (pe[qpo_pkg::PROD_YZ] + pe[qpo_pkg::PROD_WX]) <<< 1;
    ent[8] = One - ((pe[qpo_pkg::PROD_XX] + pe[qpo_pkg::PROD_YY]) <<< 1);
    for (int i = 0; i < qpo_pkg::NumEnt; i++) begin
      rnd[i]   = ent[i] + Half;
      mat_d[i] = rnd[i][EntW-1:QuatFracBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
      mat_q  <= mat_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign mat_o   = mat_q;

endmodule

>>> hw/rtl/qpo_mac.sv
// Stage three: matrix entries times the configured offset, nine products registered.
// Depends on qpo_pkg.
module qpo_mac #(
  parameter int MatW = 21,
  localparam int MulW = MatW + qpo_pkg::OffW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  qpo_pkg::in_item_t                 item_i,
  input  logic signed [MatW-1:0]            mat_i [qpo_pkg::NumEnt],
  input  logic signed [qpo_pkg::OffW-1:0]   off_i [qpo_pkg::NumOff],
  input  logic                              ready_i,
  output logic                              valid_o,
  output qpo_pkg::in_item_t                 item_o,
  output logic signed [MulW-1:0]            mul_o [qpo_pkg::NumEnt]
);

  logic                   valid_q;
  qpo_pkg::in_item_t      item_q;
  logic signed [MulW-1:0] mul_d [qpo_pkg::NumEnt];
  logic signed [MulW-1:0] mul_q [qpo_pkg::NumEnt];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int r = 0; r < qpo_pkg::NumOff; r++) begin
      for (int c = 0; c < qpo_pkg::NumOff; c++) begin
        mul_d[r * qpo_pkg::NumOff + c] = mat_i[r * qpo_pkg::NumOff + c] * off_i[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
      mul_q  <= mul_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign mul_o   = mul_q;

endmodule

>>> hw/rtl/qpo_sum.sv
// Stages four and five: row sums with rounding, then position add, saturation and output beat.
// Depends on qpo_pkg.
module qpo_sum #(
  parameter int QuatFracBits = qpo_pkg::QuatFracBitsDefault,
  parameter int MulW = 53,
  localparam int AccW = MulW + 2,
  localparam int RndW = AccW - QuatFracBits,
  localparam int SumW = ((RndW > qpo_pkg::PosW) ? RndW : qpo_pkg::PosW) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  qpo_pkg::in_item_t             item_i,
  input  logic signed [MulW-1:0]        mul_i [qpo_pkg::NumEnt],
  input  logic                          ready_i,
  output logic                          valid_o,
  output qpo_pkg::out_item_t            item_o
);

  localparam logic signed [AccW-1:0] Half   = AccW'(1) << (QuatFracBits - 1);
  localparam logic signed [SumW-1:0] SatMax = (SumW'(1) << (qpo_pkg::PosW - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] SatMin = -(SumW'(1) << (qpo_pkg::PosW - 1));

  function automatic logic [qpo_pkg::PosW-1:0] sat(input logic signed [SumW-1:0] v);
    logic [qpo_pkg::PosW-1:0] res;
    if (v > SatMax) begin
      res = SatMax[qpo_pkg::PosW-1:0];
    end else if (v < SatMin) begin
      res = SatMin[qpo_pkg::PosW-1:0];
    end else begin
      res = v[qpo_pkg::PosW-1:0];
    end
    return res;
  endfunction

  logic                               acc_vld_q;
  logic                               acc_ready;
  qpo_pkg::in_item_t                  acc_item_q;
  logic signed [AccW-1:0]             acc_d [qpo_pkg::NumOff];
  logic signed [AccW-1:0]             acc_q [qpo_pkg::NumOff];
  logic signed [RndW-1:0]             rnd   [qpo_pkg::NumOff];
  logic signed [qpo_pkg::PosW-1:0]    pos   [qpo_pkg::NumOff];
  logic signed [SumW-1:0]             tot   [qpo_pkg::NumOff];
  logic                               out_vld_q;
  qpo_pkg::out_item_t                 out_d;
  qpo_pkg::out_item_t                 out_q;

  assign acc_ready = !out_vld_q || ready_i;
  assign ready_o   = !acc_vld_q || acc_ready;

  always_comb begin
    for (int r = 0; r < qpo_pkg::NumOff; r++) begin
      acc_d[r] = AccW'(mul_i[r * qpo_pkg::NumOff])
               + AccW'(mul_i[r * qpo_pkg::NumOff + 1])
               + AccW'(mul_i[r * qpo_pkg::NumOff + 2])
               + Half;
    end
  end

  always_comb begin
    pos[0] = acc_item_q.pos_x;
    pos[1] = acc_item_q.pos_y;
    pos[2] = acc_item_q.pos_z;
    for (int r = 0; r < qpo_pkg::NumOff; r++) begin
      rnd[r] = acc_q[r][AccW-1:QuatFracBits];
      tot[r] = SumW'(rnd[r]) + SumW'(pos[r]);
    end
    out_d.out_x  = sat(tot[0]);
    out_d.out_y  = sat(tot[1]);
    out_d.out_z  = sat(tot[2]);
    out_d.out_qw = acc_item_q.quat_w;
    out_d.out_qx = acc_item_q.quat_x;
    out_d.out_qy = acc_item_q.quat_y;
    out_d.out_qz = acc_item_q.quat_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (ready_o) begin
        acc_vld_q <= valid_i;
      end
      if (acc_ready) begin
        out_vld_q <= acc_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      acc_item_q <= item_i;
      acc_q      <= acc_d;
    end
    if (acc_ready && acc_vld_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign item_o  = out_q;

endmodule

>>> hw/rtl/quaternion_pose_offset_unit.sv
// Pose offset unit: rotates the configured offset by the pose quaternion and adds the position.
// One beat per cycle sustained while out_stall_i is low.
// Five register stages: products, matrix, offset multiply, row sum, position add.
// Reset clears all stage valid bits and the three offset registers to zero.
// Depends on qpo_pkg, qpo_prod, qpo_matrix, qpo_mac, qpo_sum and assert_macros.svh.
`include "assert_macros.svh"

module quaternion_pose_offset_unit #(
  parameter int QuatFracBits = qpo_pkg::QuatFracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  qpo_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output qpo_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [qpo_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [qpo_pkg::OffW-1:0]       cfg_wdata_i
);

  localparam int EntW = (((2 * QuatFracBits + 2) > (qpo_pkg::ProdW + 2)) ?
                         (2 * QuatFracBits + 2) : (qpo_pkg::ProdW + 2)) + 1;
  localparam int MatW = EntW - QuatFracBits;
  localparam int MulW = MatW + qpo_pkg::OffW;

  logic signed [qpo_pkg::OffW-1:0]  off_q [qpo_pkg::NumOff];

  logic                             s1_vld, s2_vld, s3_vld;
  logic                             s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  qpo_pkg::in_item_t                s1_item, s2_item, s3_item;
  logic signed [qpo_pkg::ProdW-1:0] s1_prod [qpo_pkg::NumProd];
  logic signed [MatW-1:0]           s2_mat  [qpo_pkg::NumEnt];
  logic signed [MulW-1:0]           s3_mul  [qpo_pkg::NumEnt];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qpo_pkg::NumOff; i++) begin
        off_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qpo_pkg::CFG_OFFSET_X: off_q[0] <= cfg_wdata_i;
        qpo_pkg::CFG_OFFSET_Y: off_q[1] <= cfg_wdata_i;
        qpo_pkg::CFG_OFFSET_Z: off_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !s1_rdy;

  qpo_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (s1_rdy),
    .item_i  (in_data_i),
    .ready_i (s2_rdy),
    .valid_o (s1_vld),
    .item_o  (s1_item),
    .prod_o  (s1_prod)
  );

  qpo_matrix #(
    .QuatFracBits (QuatFracBits)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_vld),
    .ready_o (s2_rdy),
    .item_i  (s1_item),
    .prod_i  (s1_prod),
    .ready_i (s3_rdy),
    .valid_o (s2_vld),
    .item_o  (s2_item),
    .mat_o   (s2_mat)
  );

  qpo_mac #(
    .MatW (MatW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld),
    .ready_o (s3_rdy),
    .item_i  (s2_item),
    .mat_i   (s2_mat),
    .off_i   (off_q),
    .ready_i (s4_rdy),
    .valid_o (s3_vld),
    .item_o  (s3_item),
    .mul_o   (s3_mul)
  );

  qpo_sum #(
    .QuatFracBits (QuatFracBits),
    .MulW         (MulW)
  ) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld),
    .ready_o (s4_rdy),
    .item_i  (s3_item),
    .mul_i   (s3_mul),
    .ready_i (!out_stall_i),
    .valid_o (out_valid_o),
    .item_o  (out_data_o)
  );

  `QPO_ASSERT(a_accept_lands, (in_valid_i && !in_stall_o) |=> s1_vld, "accepted beat lost at entry")
  `QPO_ASSERT(a_stall_full, in_stall_o |-> (s1_vld && s2_vld && s3_vld && out_valid_o && out_stall_i), "stall with a free stage")
  `QPO_ASSERT(a_cfg_x, (cfg_we_i && cfg_idx_i == qpo_pkg::CFG_OFFSET_X) |=> (off_q[0] == $past(cfg_wdata_i)), "offset x write lost")
  `QPO_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "output beat during reset")

endmodule
